/* hw/rtl/rsi_pkg.sv */
// Package: shared widths, register indexes and the pipeline tag type.
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [30:0] RADIUS_RESET = 31'(1 << FRAC_BITS);
  localparam logic [15:0] MIN_DIST_RESET = 16'd66;

  localparam int B_W = 37;
  localparam int DISC_W = 75;
  localparam int REM_W = 76;
  localparam int ROOT_W = 38;

  localparam logic [2:0] REG_CENTRE_X = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y = 3'd1;
  localparam logic [2:0] REG_CENTRE_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_MIN_DIST = 3'd4;

  typedef struct packed {
    logic valid;
    logic pos;
    logic signed [B_W-1:0] b;
    logic [30:0] tmax;
  } sq_tag_t;

endpackage

/* hw/rtl/rsi_sqrt.sv */
// Pipelined floor square root, one result bit per stage, with a tag alongside.
module rsi_sqrt import rsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [REM_W-1:0] radicand,
  input  sq_tag_t tag_in,
  output logic [ROOT_W-1:0] root_out,
  output sq_tag_t tag_out
);

  logic [REM_W-1:0] rem [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  sq_tag_t tag [0:ROOT_W];

  assign rem[0] = radicand;
  assign root[0] = '0;
  assign tag[0] = tag_in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int BIT = ROOT_W - 1 - i;
    logic [REM_W-1:0] trial;
    logic take;
    assign trial = (REM_W'(root[i]) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
    assign take = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rem[i] - trial : rem[i];
        root[i+1] <= take ? (root[i] | (ROOT_W'(1) << BIT)) : root[i];
        tag[i+1].pos <= tag[i].pos;
        tag[i+1].b <= tag[i].b;
        tag[i+1].tmax <= tag[i].tmax;
      end
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else if (en) begin
        tag[i+1].valid <= tag[i].valid;
      end
    end
  end

  assign root_out = root[ROOT_W];
  assign tag_out = tag[ROOT_W];

endmodule

/* hw/rtl/ray_sphere_intersect.sv */
// Top level: pipelined ray-sphere intersection test.
// Stages from input transfer to result: 6 arithmetic stages,
// 38 square-root stages (one root bit each) and the output register.
// Throughput: one ray per cycle; the whole pipeline holds when the result is stalled.
// Reset: synchronous, clears all valid bits and restores the sphere registers.
module ray_sphere_intersect import rsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, pad
  input  logic [223:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, hit_distance, far_root, pad
  output logic [39:0] m_axis_tdata
);

  logic signed [31:0] centre_x, centre_y, centre_z;
  logic [30:0] sphere_radius;
  logic [15:0] min_distance;
  logic en;

  assign cfg_ready = 1'b1;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= '0;
      centre_y <= '0;
      centre_z <= '0;
      sphere_radius <= RADIUS_RESET;
      min_distance <= MIN_DIST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        REG_CENTRE_Z: centre_z <= cfg_data;
        REG_RADIUS: sphere_radius <= cfg_data[30:0];
        REG_MIN_DIST: min_distance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: offset from centre
  logic v1;
  logic signed [32:0] vx, vy, vz;
  logic signed [31:0] ux, uy, uz;
  logic [30:0] tmax1;
  always_ff @(posedge clk) begin
    if (en) begin
      vx <= 33'(signed'(s_axis_tdata[31:0])) - 33'(centre_x);
      vy <= 33'(signed'(s_axis_tdata[63:32])) - 33'(centre_y);
      vz <= 33'(signed'(s_axis_tdata[95:64])) - 33'(centre_z);
      ux <= s_axis_tdata[127:96];
      uy <= s_axis_tdata[159:128];
      uz <= s_axis_tdata[191:160];
      tmax1 <= s_axis_tdata[222:192];
    end
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_axis_tvalid;
  end

  // stage 2: products
  logic v2;
  logic signed [64:0] pux, puy, puz;
  logic signed [65:0] pvx, pvy, pvz;
  logic [61:0] rr;
  logic [30:0] tmax2;
  always_ff @(posedge clk) begin
    if (en) begin
      pux <= vx * ux;
      puy <= vy * uy;
      puz <= vz * uz;
      pvx <= vx * vx;
      pvy <= vy * vy;
      pvz <= vz * vz;
      rr <= sphere_radius * sphere_radius;
      tmax2 <= tmax1;
    end
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  // stage 3: sums
  logic v3;
  logic signed [66:0] dotv;
  logic signed [68:0] c3;
  logic [30:0] tmax3;
  always_ff @(posedge clk) begin
    if (en) begin
      dotv <= 67'(pux) + 67'(puy) + 67'(puz);
      c3 <= 69'(pvx) + 69'(pvy) + 69'(pvz) - 69'(signed'({1'b0, rr}));
      tmax3 <= tmax2;
    end
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  // stage 4: b by floor shift
  logic v4;
  logic signed [B_W-1:0] b4;
  logic signed [68:0] c4;
  logic [30:0] tmax4;
  always_ff @(posedge clk) begin
    if (en) begin
      b4 <= dotv[66:30];
      c4 <= c3;
      tmax4 <= tmax3;
    end
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  // stage 5: b squared
  logic v5;
  logic signed [B_W-1:0] b5;
  logic signed [73:0] b2;
  logic signed [68:0] c5;
  logic [30:0] tmax5;
  always_ff @(posedge clk) begin
    if (en) begin
      b2 <= b4 * b4;
      b5 <= b4;
      c5 <= c4;
      tmax5 <= tmax4;
    end
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  // stage 6: discriminant
  logic signed [DISC_W-1:0] disc_c;
  logic [REM_W-1:0] disc6;
  sq_tag_t tag6;
  assign disc_c = 75'(b2) - 75'(c5);
  always_ff @(posedge clk) begin
    if (en) begin
      disc6 <= disc_c[DISC_W-1] ? '0 : {1'b0, disc_c};
      tag6.pos <= !disc_c[DISC_W-1] && (disc_c != '0);
      tag6.b <= b5;
      tag6.tmax <= tmax5;
    end
    if (rst) tag6.valid <= 1'b0;
    else if (en) tag6.valid <= v5;
  end

  logic [ROOT_W-1:0] s_root;
  sq_tag_t tag_s;

  rsi_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .radicand(disc6),
    .tag_in(tag6),
    .root_out(s_root),
    .tag_out(tag_s)
  );

  // final stage: root selection
  logic signed [39:0] nb, tn, tf, eps40, tmax40;
  logic near_ok, far_ok;
  assign nb = -{{3{tag_s.b[B_W-1]}}, tag_s.b};
  assign tn = nb - {2'b0, s_root};
  assign tf = nb + {2'b0, s_root};
  assign eps40 = {24'b0, min_distance};
  assign tmax40 = {9'b0, tag_s.tmax};
  assign near_ok = tag_s.pos && (tn > eps40) && (tn < tmax40);
  assign far_ok = tag_s.pos && (tf > eps40) && (tf < tmax40);

  logic hit, far_root;
  logic [30:0] hit_distance;
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= near_ok || far_ok;
      far_root <= !near_ok && far_ok;
      hit_distance <= near_ok ? tn[30:0] : (far_ok ? tf[30:0] : '0);
    end
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= tag_s.valid;
  end

  assign m_axis_tdata = {7'b0, far_root, hit_distance, hit};

`ifndef SYNTHESIS
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !hit |-> hit_distance == '0 && !far_root)
    else $error("miss result carries nonzero fields");
  a_far_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && far_root |-> hit)
    else $error("far root without hit");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_ready_tie: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with pipeline advance");
`endif

endmodule
